/* src/tcst_pkg.sv */
// shared types, constants and helpers for the touch contact slot tracker
package tcst_pkg;

  localparam int NUM_SLOTS = 10;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ID_W      = 64;
  localparam int POS_W     = 12;
  localparam int MODE_W    = 3;
  localparam int KIND_W    = 2;
  localparam int SLOTF_W   = 4;

  // input modes
  localparam logic [MODE_W-1:0] MODE_FINGER_DOWN   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FINGER_UP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FINGER_MOTION = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MOUSE_DOWN    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MOUSE_UP      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MOUSE_MOTION  = 3'd5;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PRIMARY_BUTTON = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRIMARY_MOTION = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TOUCH_BUTTON   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TOUCH_MOTION   = 2'd3;

  // one slot entry as read from the table
  typedef struct packed {
    logic             busy;
    logic [ID_W-1:0]  finger;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } slot_rd_t;

  // write command into the table
  typedef struct packed {
    logic              busy_set;
    logic              busy_clr;
    logic              finger_we;
    logic              pos_we;
    logic [SLOT_W-1:0] idx;
    logic [ID_W-1:0]   finger;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
  } slot_wr_t;

  // flags from the shared compare unit
  typedef struct packed {
    logic hit;
    logic free;
    logic same_pos;
  } match_t;

  // one result toward the output register
  typedef struct packed {
    logic               valid;
    logic [KIND_W-1:0]  kind;
    logic [SLOTF_W-1:0] slot;
    logic               pressed;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic               last;
  } result_t;

  // slot number into the four-bit field, low bits kept
  function automatic logic [SLOTF_W-1:0] slot_to_field(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+SLOTF_W-1:0] tmp;
    tmp = {{SLOTF_W{1'b0}}, s};
    return tmp[SLOTF_W-1:0];
  endfunction

endpackage

/* src/tcst_slot_table.sv */
// contact slot table: busy bits, finger ids and stored positions
module tcst_slot_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tcst_pkg::SLOT_W-1:0] rd_idx,
  output tcst_pkg::slot_rd_t          rd,
  input  tcst_pkg::slot_wr_t          wr
);

  logic [tcst_pkg::NUM_SLOTS-1:0] busy;
  logic [tcst_pkg::ID_W-1:0]      finger [tcst_pkg::NUM_SLOTS];
  logic [tcst_pkg::POS_W-1:0]     pos_x  [tcst_pkg::NUM_SLOTS];
  logic [tcst_pkg::POS_W-1:0]     pos_y  [tcst_pkg::NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (wr.busy_set) begin
      busy[wr.idx] <= 1'b1;
    end else if (wr.busy_clr) begin
      busy[wr.idx] <= 1'b0;
    end
  end

  // entries carry no reset, only read while busy
  always_ff @(posedge clk) begin
    if (wr.finger_we) begin
      finger[wr.idx] <= wr.finger;
    end
    if (wr.pos_we) begin
      pos_x[wr.idx] <= wr.x;
      pos_y[wr.idx] <= wr.y;
    end
  end

  always_comb begin
    rd.busy   = busy[rd_idx];
    rd.finger = finger[rd_idx];
    rd.x      = pos_x[rd_idx];
    rd.y      = pos_y[rd_idx];
  end

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (wr.busy_clr && !wr.busy_set) |=> !busy[$past(wr.idx)])
    else $error("released slot still busy");

endmodule

/* src/tcst_match_unit.sv */
// shared compare unit: id match, free slot and position equality
module tcst_match_unit (
  input  tcst_pkg::slot_rd_t         entry,
  input  logic [tcst_pkg::ID_W-1:0]  id,
  input  logic [tcst_pkg::POS_W-1:0] x,
  input  logic [tcst_pkg::POS_W-1:0] y,
  output tcst_pkg::match_t           flags
);

  always_comb begin
    flags.hit      = entry.busy && (entry.finger == id);
    flags.free     = !entry.busy;
    flags.same_pos = (entry.x == x) && (entry.y == y);
  end

endmodule

/* src/tcst_seq.sv */
// sequencer: slot scan, table update and result generation
module tcst_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcst_pkg::MODE_W-1:0] in_mode,
  input  logic [tcst_pkg::ID_W-1:0]   in_id,
  input  logic [tcst_pkg::POS_W-1:0]  in_x,
  input  logic [tcst_pkg::POS_W-1:0]  in_y,
  output logic [tcst_pkg::SLOT_W-1:0] rd_idx,
  input  tcst_pkg::slot_rd_t          rd,
  output tcst_pkg::slot_wr_t          wr,
  output tcst_pkg::result_t           res,
  input  logic                        res_ready
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_EMIT0  = 5'b01000,
    ST_EMIT1  = 5'b10000
  } state_t;

  localparam logic [tcst_pkg::SLOT_W-1:0] LAST_IDX = tcst_pkg::SLOT_W'(tcst_pkg::NUM_SLOTS - 1);

  state_t state, state_next;

  logic [tcst_pkg::MODE_W-1:0] mode;
  logic [tcst_pkg::ID_W-1:0]   id;
  logic [tcst_pkg::POS_W-1:0]  pos_x;
  logic [tcst_pkg::POS_W-1:0]  pos_y;
  logic [tcst_pkg::SLOT_W-1:0] idx;
  logic                        hit;
  logic [tcst_pkg::SLOT_W-1:0] hit_idx;
  logic                        pos_same;
  logic                        free_found;
  logic [tcst_pkg::SLOT_W-1:0] free_idx;
  logic [tcst_pkg::SLOT_W-1:0] slot;

  tcst_pkg::match_t flags;
  logic                        act;
  logic [tcst_pkg::SLOT_W-1:0] slot_sel;
  logic                        is_motion;
  logic                        is_press;

  tcst_match_unit u_match (
    .entry (rd),
    .id    (id),
    .x     (pos_x),
    .y     (pos_y),
    .flags (flags)
  );

  assign rd_idx   = idx;
  assign in_ready = (state == ST_IDLE);

  assign is_motion = (mode == tcst_pkg::MODE_FINGER_MOTION) ||
                     (mode == tcst_pkg::MODE_MOUSE_MOTION);
  assign is_press  = (mode == tcst_pkg::MODE_FINGER_DOWN) ||
                     (mode == tcst_pkg::MODE_MOUSE_DOWN);

  // decision after the scan
  always_comb begin
    act      = 1'b0;
    slot_sel = hit_idx;
    wr       = '0;
    wr.idx    = hit_idx;
    wr.finger = id;
    wr.x      = pos_x;
    wr.y      = pos_y;
    case (mode)
      tcst_pkg::MODE_FINGER_DOWN: begin
        act      = hit || free_found;
        slot_sel = hit ? hit_idx : free_idx;
      end
      tcst_pkg::MODE_FINGER_UP: begin
        act = hit;
      end
      tcst_pkg::MODE_FINGER_MOTION: begin
        act = hit && !pos_same;
      end
      default: begin
        act = 1'b0;
      end
    endcase
    wr.idx = slot_sel;
    if (state == ST_DECIDE && act) begin
      wr.busy_set  = (mode == tcst_pkg::MODE_FINGER_DOWN);
      wr.finger_we = (mode == tcst_pkg::MODE_FINGER_DOWN);
      wr.busy_clr  = (mode == tcst_pkg::MODE_FINGER_UP);
      wr.pos_we    = (mode == tcst_pkg::MODE_FINGER_DOWN) ||
                     (mode == tcst_pkg::MODE_FINGER_MOTION);
    end
  end

  // result toward the output register
  always_comb begin
    res         = '0;
    res.x       = pos_x;
    res.y       = pos_y;
    res.pressed = is_press && !is_motion;
    case (state)
      ST_EMIT0: begin
        res.valid = 1'b1;
        res.kind  = is_motion ? tcst_pkg::KIND_TOUCH_MOTION : tcst_pkg::KIND_TOUCH_BUTTON;
        res.slot  = tcst_pkg::slot_to_field(slot);
        res.last  = (slot != '0);
      end
      ST_EMIT1: begin
        res.valid = 1'b1;
        res.kind  = is_motion ? tcst_pkg::KIND_PRIMARY_MOTION : tcst_pkg::KIND_PRIMARY_BUTTON;
        res.slot  = '0;
        res.last  = 1'b1;
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == tcst_pkg::MODE_FINGER_DOWN || in_mode == tcst_pkg::MODE_FINGER_UP ||
              in_mode == tcst_pkg::MODE_FINGER_MOTION) begin
            state_next = ST_SCAN;
          end else if (in_mode == tcst_pkg::MODE_MOUSE_DOWN ||
                       in_mode == tcst_pkg::MODE_MOUSE_UP ||
                       in_mode == tcst_pkg::MODE_MOUSE_MOTION) begin
            state_next = ST_EMIT0;
          end
        end
      end
      ST_SCAN: begin
        if (flags.hit || idx == LAST_IDX) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = act ? ST_EMIT0 : ST_IDLE;
      end
      ST_EMIT0: begin
        if (res_ready) begin
          state_next = (slot == '0) ? ST_EMIT1 : ST_IDLE;
        end
      end
      ST_EMIT1: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        mode       <= in_mode;
        id         <= in_id;
        pos_x      <= in_x;
        pos_y      <= in_y;
        idx        <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
        slot       <= '0;
      end
      ST_SCAN: begin
        if (flags.hit) begin
          hit      <= 1'b1;
          hit_idx  <= idx;
          pos_same <= flags.same_pos;
        end else begin
          if (flags.free && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (idx != LAST_IDX) begin
            idx <= idx + 1'b1;
          end
        end
      end
      ST_DECIDE: begin
        slot <= slot_sel;
      end
      default: begin
      end
    endcase
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (idx <= LAST_IDX))
    else $error("scan index past the last slot");

  a_dup_on_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT1) |-> (slot == '0))
    else $error("primary duplicate for a slot other than zero");

  a_write_only_decide: assert property (@(posedge clk) disable iff (rst)
    (wr.busy_set || wr.busy_clr || wr.pos_we) |=> (state == ST_EMIT0))
    else $error("table written without a result following");

endmodule

/* src/touch_contact_slot_tracker.sv */
// top level of the touch contact slot tracker
// sequence: a mouse item goes from idle straight to its results; a finger item is
//   scanned one slot a cycle until a match or the last slot, decided, then results if it acts
// one item at a time: a new item is taken only in idle, after the scan, decide and
//   result states of the last item; output stalls hold the result states
// reset: synchronous, clears busy bits and empties the output register, entries kept
module touch_contact_slot_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // finger_id[63:0], pos_x[75:64], pos_y[87:76]
  input  logic [2:0]  s_tuser,   // mode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // slot_index[3:0], is_pressed[4], out_x[16:5], out_y[28:17], zero
  output logic [1:0]  m_tuser,   // event_kind[1:0]
  output logic        m_tlast    // last_of_run
);

  logic [tcst_pkg::SLOT_W-1:0] rd_idx;
  tcst_pkg::slot_rd_t          rd;
  tcst_pkg::slot_wr_t          wr;
  tcst_pkg::result_t           res;
  logic                        out_free;

  // output register state
  logic                         out_valid;
  logic [tcst_pkg::KIND_W-1:0]  out_kind;
  logic [tcst_pkg::SLOTF_W-1:0] out_slot;
  logic                         out_pressed;
  logic [tcst_pkg::POS_W-1:0]   out_x;
  logic [tcst_pkg::POS_W-1:0]   out_y;
  logic                         out_last;

  tcst_slot_table u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rd_idx),
    .rd     (rd),
    .wr     (wr)
  );

  tcst_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_id     (s_tdata[63:0]),
    .in_x      (s_tdata[75:64]),
    .in_y      (s_tdata[87:76]),
    .rd_idx    (rd_idx),
    .rd        (rd),
    .wr        (wr),
    .res       (res),
    .res_ready (out_free)
  );

  // the output register takes a new result when empty or being drained
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      out_kind    <= res.kind;
      out_slot    <= res.slot;
      out_pressed <= res.pressed;
      out_x       <= res.x;
      out_y       <= res.y;
      out_last    <= res.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {3'b000, out_y, out_x, out_pressed, out_slot};

  // only a slot zero touch result is followed by a duplicate
  a_first_of_pair_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[3:0] == 4'd0))
    else $error("result without last flag on a slot other than zero");

endmodule

/* tb/sv/tb_touch_contact_slot_tracker.sv */
// testbench for the touch contact slot tracker: directed table then random finger and mouse traffic
module tb_touch_contact_slot_tracker;

  localparam int LIMIT_CYCLES  = 300000;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int POOL_SIZE     = 14;
  localparam int PREDICTED     = -1;

  // mode codes the block ignores
  localparam logic [tcst_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [tcst_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  localparam logic [tcst_pkg::POS_W-1:0] POS_MAX = '1;
  localparam logic [tcst_pkg::ID_W-1:0]  ID_MAX  = '1;

  typedef struct packed {
    logic [tcst_pkg::KIND_W-1:0]  kind;
    logic [tcst_pkg::SLOTF_W-1:0] slot;
    logic                         pressed;
    logic [tcst_pkg::POS_W-1:0]   x;
    logic [tcst_pkg::POS_W-1:0]   y;
    logic                         last;
  } touch_event_t;

  typedef struct {
    logic [tcst_pkg::MODE_W-1:0] mode;
    logic [tcst_pkg::ID_W-1:0]   id;
    logic [tcst_pkg::POS_W-1:0]  x;
    logic [tcst_pkg::POS_W-1:0]  y;
    int                          typed;   // number of hand-written results, or PREDICTED
    touch_event_t                t0;
    touch_event_t                t1;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;   // finger_id[63:0], pos_x[75:64], pos_y[87:76]
  logic [2:0]  s_tuser = '0;   // mode[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // slot_index[3:0], is_pressed[4], out_x[16:5], out_y[28:17], zero
  logic [1:0]  m_tuser;        // event_kind[1:0]
  logic        m_tlast;        // last_of_run

  touch_contact_slot_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // contact table as the block should hold it
  logic                       held_busy   [tcst_pkg::NUM_SLOTS] = '{default: 1'b0};
  logic [tcst_pkg::ID_W-1:0]  held_finger [tcst_pkg::NUM_SLOTS] = '{default: '0};
  logic [tcst_pkg::POS_W-1:0] held_x      [tcst_pkg::NUM_SLOTS] = '{default: '0};
  logic [tcst_pkg::POS_W-1:0] held_y      [tcst_pkg::NUM_SLOTS] = '{default: '0};

  touch_event_t fresh_events[$];     // results of the item just transferred
  touch_event_t awaited_events[$];   // results still due from the block
  stim_row_t    stim_rows[$];
  logic [tcst_pkg::ID_W-1:0] finger_pool[POOL_SIZE];

  int mismatch_count = 0;
  int cycle_count    = 0;
  bit noisy          = 1'b0;   // random idling on both sides
  bit hold_req       = 1'b0;   // asks the receiver for one long hold-off

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results still due", cycle_count,
           awaited_events.size());
    $display("status: fail");
    $finish;
  end

  function automatic touch_event_t ev(input logic [tcst_pkg::KIND_W-1:0] kind,
                                      input logic [tcst_pkg::SLOTF_W-1:0] slot,
                                      input logic pressed,
                                      input logic [tcst_pkg::POS_W-1:0] x,
                                      input logic [tcst_pkg::POS_W-1:0] y,
                                      input logic last);
    touch_event_t e;
    e.kind = kind; e.slot = slot; e.pressed = pressed;
    e.x = x; e.y = y; e.last = last;
    return e;
  endfunction

  function automatic int find_slot(input logic [tcst_pkg::ID_W-1:0] id);
    for (int i = 0; i < tcst_pkg::NUM_SLOTS; i++)
      if (held_busy[i] && held_finger[i] == id) return i;
    return -1;
  endfunction

  // touch result on a slot, slot 0 also mirrored onto the primary pointer
  function automatic void post(input logic [tcst_pkg::KIND_W-1:0] touch_kind,
                               input logic [tcst_pkg::KIND_W-1:0] primary_kind, input int s,
                               input logic pressed, input logic [tcst_pkg::POS_W-1:0] x,
                               input logic [tcst_pkg::POS_W-1:0] y);
    fresh_events.insert(fresh_events.size(),
                        ev(touch_kind, s[tcst_pkg::SLOTF_W-1:0], pressed, x, y, s != 0));
    if (s == 0)
      fresh_events.insert(fresh_events.size(), ev(primary_kind, '0, pressed, x, y, 1'b1));
  endfunction

  function automatic void track_contact(input logic [tcst_pkg::MODE_W-1:0] mode,
                                        input logic [tcst_pkg::ID_W-1:0] id,
                                        input logic [tcst_pkg::POS_W-1:0] x,
                                        input logic [tcst_pkg::POS_W-1:0] y);
    int s;
    fresh_events.delete();
    s = find_slot(id);
    case (mode)
      tcst_pkg::MODE_FINGER_DOWN: begin
        if (s < 0) begin
          // lowest free slot
          for (int i = 0; i < tcst_pkg::NUM_SLOTS && s < 0; i++)
            if (!held_busy[i]) s = i;
          if (s >= 0) begin
            held_busy[s]   = 1'b1;
            held_finger[s] = id;
          end
        end
        if (s >= 0) begin
          held_x[s] = x;
          held_y[s] = y;
          post(tcst_pkg::KIND_TOUCH_BUTTON, tcst_pkg::KIND_PRIMARY_BUTTON, s, 1'b1, x, y);
        end
      end
      tcst_pkg::MODE_FINGER_UP: begin
        if (s >= 0) begin
          held_busy[s] = 1'b0;
          post(tcst_pkg::KIND_TOUCH_BUTTON, tcst_pkg::KIND_PRIMARY_BUTTON, s, 1'b0, x, y);
        end
      end
      tcst_pkg::MODE_FINGER_MOTION: begin
        if (s >= 0 && (held_x[s] != x || held_y[s] != y)) begin
          held_x[s] = x;
          held_y[s] = y;
          post(tcst_pkg::KIND_TOUCH_MOTION, tcst_pkg::KIND_PRIMARY_MOTION, s, 1'b0, x, y);
        end
      end
      tcst_pkg::MODE_MOUSE_DOWN:
        post(tcst_pkg::KIND_TOUCH_BUTTON, tcst_pkg::KIND_PRIMARY_BUTTON, 0, 1'b1, x, y);
      tcst_pkg::MODE_MOUSE_UP:
        post(tcst_pkg::KIND_TOUCH_BUTTON, tcst_pkg::KIND_PRIMARY_BUTTON, 0, 1'b0, x, y);
      tcst_pkg::MODE_MOUSE_MOTION:
        post(tcst_pkg::KIND_TOUCH_MOTION, tcst_pkg::KIND_PRIMARY_MOTION, 0, 1'b0, x, y);
      default: ;
    endcase
  endfunction

  function automatic logic [tcst_pkg::POS_W-1:0] pick_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return POS_MAX;
    return tcst_pkg::POS_W'($urandom);
  endfunction

  task automatic add_row(input logic [tcst_pkg::MODE_W-1:0] mode,
                         input logic [tcst_pkg::ID_W-1:0] id,
                         input logic [tcst_pkg::POS_W-1:0] x,
                         input logic [tcst_pkg::POS_W-1:0] y,
                         input int typed, input touch_event_t t0, input touch_event_t t1);
    stim_row_t row;
    row.mode = mode; row.id = id; row.x = x; row.y = y;
    row.typed = typed; row.t0 = t0; row.t1 = t1;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  // offer one item until it is transferred, then update the table copy
  task automatic offer(input logic [tcst_pkg::MODE_W-1:0] mode,
                       input logic [tcst_pkg::ID_W-1:0] id,
                       input logic [tcst_pkg::POS_W-1:0] x,
                       input logic [tcst_pkg::POS_W-1:0] y);
    while (noisy && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {y, x, id};
    do @(posedge clk); while (!s_tready);
    track_contact(mode, id, x, y);
  endtask

  task automatic await_predicted();
    foreach (fresh_events[k]) awaited_events.insert(awaited_events.size(), fresh_events[k]);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_events.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: checks each result transfer and paces m_tready
  initial begin
    int hold_left;
    touch_event_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (awaited_events.size() == 0) begin
          $error("result transfer with nothing due: kind %0d slot %0d", m_tuser, m_tdata[3:0]);
          mismatch_count++;
        end else begin
          want = awaited_events.pop_front();
          check_field("event_kind", 64'(want.kind), 64'(m_tuser));
          check_field("slot_index", 64'(want.slot), 64'(m_tdata[3:0]));
          check_field("is_pressed", 64'(want.pressed), 64'(m_tdata[4]));
          check_field("out_x", 64'(want.x), 64'(m_tdata[16:5]));
          check_field("out_y", 64'(want.y), 64'(m_tdata[28:17]));
          check_field("last_of_run", 64'(want.last), 64'(m_tlast));
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !noisy || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // sender
  initial begin
    logic [tcst_pkg::MODE_W-1:0] mode;
    logic [tcst_pkg::ID_W-1:0]   id;
    logic [tcst_pkg::POS_W-1:0]  x;
    logic [tcst_pkg::POS_W-1:0]  y;
    int r;
    int s;
    int counted;
    touch_event_t none;

    none = '0;

    // outside events: extremes, ignored modes, unknown fingers
    add_row(tcst_pkg::MODE_MOUSE_DOWN, '0, '0, '0, 2,
            ev(tcst_pkg::KIND_TOUCH_BUTTON, '0, 1'b1, '0, '0, 1'b0),
            ev(tcst_pkg::KIND_PRIMARY_BUTTON, '0, 1'b1, '0, '0, 1'b1));
    add_row(tcst_pkg::MODE_MOUSE_UP, ID_MAX, POS_MAX, POS_MAX, 2,
            ev(tcst_pkg::KIND_TOUCH_BUTTON, '0, 1'b0, POS_MAX, POS_MAX, 1'b0),
            ev(tcst_pkg::KIND_PRIMARY_BUTTON, '0, 1'b0, POS_MAX, POS_MAX, 1'b1));
    add_row(tcst_pkg::MODE_MOUSE_MOTION, '0, POS_MAX, '0, 2,
            ev(tcst_pkg::KIND_TOUCH_MOTION, '0, 1'b0, POS_MAX, '0, 1'b0),
            ev(tcst_pkg::KIND_PRIMARY_MOTION, '0, 1'b0, POS_MAX, '0, 1'b1));
    add_row(MODE_UNUSED_LO, 64'd1, 12'd1, 12'd1, 0, none, none);
    add_row(MODE_UNUSED_HI, ID_MAX, POS_MAX, POS_MAX, 0, none, none);
    add_row(tcst_pkg::MODE_FINGER_UP, 64'd7, 12'd10, 12'd20, 0, none, none);
    add_row(tcst_pkg::MODE_FINGER_MOTION, 64'd7, 12'd10, 12'd20, 0, none, none);
    // first contacts land in slots 0 and 1
    add_row(tcst_pkg::MODE_FINGER_DOWN, '0, '0, '0, 2,
            ev(tcst_pkg::KIND_TOUCH_BUTTON, '0, 1'b1, '0, '0, 1'b0),
            ev(tcst_pkg::KIND_PRIMARY_BUTTON, '0, 1'b1, '0, '0, 1'b1));
    add_row(tcst_pkg::MODE_FINGER_DOWN, ID_MAX, POS_MAX, POS_MAX, 1,
            ev(tcst_pkg::KIND_TOUCH_BUTTON, 4'd1, 1'b1, POS_MAX, POS_MAX, 1'b1), none);
    // motion onto the stored position says nothing
    add_row(tcst_pkg::MODE_FINGER_MOTION, ID_MAX, POS_MAX, POS_MAX, 0, none, none);
    add_row(tcst_pkg::MODE_FINGER_MOTION, ID_MAX, '0, POS_MAX, PREDICTED, none, none);
    // second press of a held finger
    add_row(tcst_pkg::MODE_FINGER_DOWN, '0, 12'd123, 12'd456, PREDICTED, none, none);
    for (int f = 2; f < tcst_pkg::NUM_SLOTS; f++)
      add_row(tcst_pkg::MODE_FINGER_DOWN, tcst_pkg::ID_W'(f), tcst_pkg::POS_W'(f * 401),
              tcst_pkg::POS_W'(4095 - f * 300), PREDICTED, none, none);
    // table full, the new finger is dropped
    add_row(tcst_pkg::MODE_FINGER_DOWN, 64'hA5A5_5A5A_0F0F_F0F0, 12'd55, 12'd66, 0,
            none, none);
    add_row(tcst_pkg::MODE_FINGER_UP, '0, 12'd77, 12'd4000, 2,
            ev(tcst_pkg::KIND_TOUCH_BUTTON, '0, 1'b0, 12'd77, 12'd4000, 1'b0),
            ev(tcst_pkg::KIND_PRIMARY_BUTTON, '0, 1'b0, 12'd77, 12'd4000, 1'b1));
    add_row(tcst_pkg::MODE_FINGER_MOTION, 64'd5, 12'd5, 12'd5, PREDICTED, none, none);
    add_row(tcst_pkg::MODE_FINGER_UP, ID_MAX, '0, '0, 1,
            ev(tcst_pkg::KIND_TOUCH_BUTTON, 4'd1, 1'b0, '0, '0, 1'b1), none);

    // fingers of the directed part stay in the pool so their slots get freed
    finger_pool[0] = '0;
    finger_pool[1] = ID_MAX;
    for (int f = 2; f < POOL_SIZE; f++)
      finger_pool[f] = (f < tcst_pkg::NUM_SLOTS) ? tcst_pkg::ID_W'(f) : {$urandom, $urandom};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      offer(stim_rows[i].mode, stim_rows[i].id, stim_rows[i].x, stim_rows[i].y);
      if (stim_rows[i].typed == PREDICTED) begin
        await_predicted();
      end else begin
        if (stim_rows[i].typed > 0)
          awaited_events.insert(awaited_events.size(), stim_rows[i].t0);
        if (stim_rows[i].typed > 1)
          awaited_events.insert(awaited_events.size(), stim_rows[i].t1);
      end
    end
    drain();

    // random traffic: mostly finger sessions over a small pool of fingers
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r  = $urandom_range(0, 99);
      id = finger_pool[$urandom_range(0, POOL_SIZE - 1)];
      x  = pick_pos();
      y  = pick_pos();
      if (r < 30) begin
        mode = tcst_pkg::MODE_FINGER_DOWN;
      end else if (r < 50) begin
        mode = tcst_pkg::MODE_FINGER_UP;
      end else if (r < 80) begin
        mode = tcst_pkg::MODE_FINGER_MOTION;
        s = find_slot(id);
        if (s >= 0 && $urandom_range(0, 2) == 0) begin
          x = held_x[s];
          y = held_y[s];
        end
      end else if (r < 92) begin
        mode = (r < 86) ? tcst_pkg::MODE_MOUSE_MOTION :
               (r < 89) ? tcst_pkg::MODE_MOUSE_DOWN : tcst_pkg::MODE_MOUSE_UP;
      end else if (r < 95) begin
        mode = $urandom_range(0, 1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
      end else begin
        // finger never seen, then maybe swap it into the pool
        id   = {$urandom, $urandom};
        mode = $urandom_range(0, 1) ? tcst_pkg::MODE_FINGER_UP : tcst_pkg::MODE_FINGER_MOTION;
        s    = $urandom_range(tcst_pkg::NUM_SLOTS, POOL_SIZE - 1);
        if (r == 99 && find_slot(finger_pool[s]) < 0) finger_pool[s] = id;
      end

      offer(mode, id, x, y);
      await_predicted();

      if (mode != MODE_UNUSED_LO && mode != MODE_UNUSED_HI) begin
        counted++;
        if (counted == 300) noisy = 1'b1;
        if (counted == 600) hold_req = 1'b1;   // receiver stalls while items keep coming
        if (counted == 900) drain();
      end
    end
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
src/tcst_pkg.sv
src/tcst_slot_table.sv
src/tcst_match_unit.sv
src/tcst_seq.sv
src/touch_contact_slot_tracker.sv
tb/sv/tb_touch_contact_slot_tracker.sv
